// ===== sv/hpid_pkg.sv =====
// shared types, constants and tables for the heading pid controller
`timescale 1ns / 1ps
package hpid_pkg;

  // cordic datapath widths
  localparam int XW = 28;
  localparam int ZW = 29;
  localparam int ATAN_LEN = 24;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic signed [ZW-1:0] Q24_PI = 29'sd52707179;

  // atan(2^-i) in Q.24 radians
  localparam int ATAN_Q24 [0:ATAN_LEN-1] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  // configuration register indexes
  localparam logic [2:0] REG_GAIN_P = 3'd0;
  localparam logic [2:0] REG_GAIN_I = 3'd1;
  localparam logic [2:0] REG_GAIN_D = 3'd2;
  localparam logic [2:0] REG_MAX_VEL = 3'd3;
  localparam logic [2:0] REG_GOAL_THR = 3'd4;
  localparam logic [2:0] REG_PRIOR_GOAL = 3'd5;

  // data handed from cell to cell
  typedef struct packed {
    logic                 valid;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_beat_t;

  // configuration register set
  typedef struct packed {
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
    logic [14:0]        vel_limit;
    logic [12:0]        goal_change_threshold;
    logic signed [15:0] prior_goal_heading;
  } cfg_regs_t;

  // post-processing sequencer
  typedef enum logic [2:0] {
    S_IDLE, S_CORDIC, S_ERR, S_INTG, S_MUL, S_SUM, S_DONE
  } pid_state_t;

endpackage

// ===== sv/hpid_cell.sv =====
// one cordic vectoring cell with a fixed shift
`timescale 1ns / 1ps
module hpid_cell #(
  parameter int STEP = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hpid_pkg::cordic_beat_t beat_in,
  output hpid_pkg::cordic_beat_t beat_out
);

  localparam logic signed [hpid_pkg::ZW-1:0] ANG = hpid_pkg::ZW'(hpid_pkg::ATAN_Q24[STEP]);

  hpid_pkg::cordic_beat_t beat_r;
  logic signed [hpid_pkg::XW-1:0] xs, ys;

  assign xs = beat_in.x >>> STEP;
  assign ys = beat_in.y >>> STEP;

  // rotate toward the x axis
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.valid <= 1'b0;
    end else begin
      beat_r.valid <= beat_in.valid;
    end
    if (beat_in.y > 0) begin
      beat_r.x <= beat_in.x + ys;
      beat_r.y <= beat_in.y - xs;
      beat_r.z <= beat_in.z + ANG;
    end else begin
      beat_r.x <= beat_in.x - ys;
      beat_r.y <= beat_in.y + xs;
      beat_r.z <= beat_in.z - ANG;
    end
  end

  assign beat_out = beat_r;

endmodule

// ===== sv/hpid_pid.sv =====
// heading error, integrator, pid sum and output register
`timescale 1ns / 1ps
module hpid_pid (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      chain_done,
  input  logic signed [hpid_pkg::ZW-1:0] chain_z,
  input  logic                      zero_vec,
  input  logic signed [15:0]        robot_heading,
  input  logic signed [15:0]        target_heading,
  input  hpid_pkg::cfg_regs_t       cfg,
  input  logic                      out_tready,
  output logic                      idle,
  output logic                      out_tvalid,
  output logic signed [15:0]        turn_velocity,
  output logic signed [15:0]        heading_error,
  output logic                      goal_reached
);

  localparam logic signed [17:0] PI18 = 18'sd25736;
  localparam logic signed [17:0] TWO_PI18 = 18'sd51472;

  hpid_pkg::pid_state_t state_r, state_nxt;

  logic signed [16:0] bearing_r;
  logic               reach_r, clear_r;
  logic signed [15:0] err_r, last_error_r;
  logic signed [31:0] error_sum_r;
  logic signed [16:0] deriv_r;
  logic signed [31:0] prod_p_r;
  logic signed [47:0] prod_i_r;
  logic signed [32:0] prod_d_r;
  logic signed [49:0] acc_r;
  logic               out_valid_r;
  logic signed [15:0] vel_out_r, err_out_r;
  logic               reach_out_r;

  logic               out_load;

  // reduce an angle difference into (-pi, pi]
  function automatic logic signed [15:0] wrap_q13(input logic signed [17:0] d);
    logic signed [17:0] m;
    begin
      m = d;
      if (d > PI18) begin
        m = d - TWO_PI18;
      end else if (d <= -PI18) begin
        m = d + TWO_PI18;
      end
      return m[15:0];
    end
  endfunction

  // rounding of the cordic angle and the heading compares
  logic signed [29:0] z_round;
  logic signed [15:0] goal_diff, reach_diff;
  logic signed [15:0] goal_abs, reach_abs;

  assign z_round = 30'(chain_z) + 30'sd1024;
  assign goal_diff = wrap_q13(18'(target_heading) - 18'(cfg.prior_goal_heading));
  assign reach_diff = wrap_q13(18'(target_heading) - 18'(robot_heading));
  assign goal_abs = goal_diff[15] ? -goal_diff : goal_diff;
  assign reach_abs = reach_diff[15] ? -reach_diff : reach_diff;

  // integrator add with saturation
  logic signed [32:0] sum_wide;
  logic signed [31:0] sum_sat;

  assign sum_wide = 33'(error_sum_r) + 33'(err_r);
  always_comb begin
    if (sum_wide[32] != sum_wide[31]) begin
      sum_sat = sum_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sum_sat = sum_wide[31:0];
    end
  end

  // rounding and clamp of the pid sum
  logic signed [50:0] acc_round;
  logic signed [33:0] vel_full, lim, vel_clamp;

  assign acc_round = 51'(acc_r) + 51'sd65536;
  assign vel_full = acc_round[50:17];
  assign lim = $signed({19'd0, cfg.vel_limit});
  always_comb begin
    if (vel_full > lim) begin
      vel_clamp = lim;
    end else if (vel_full < -lim) begin
      vel_clamp = -lim;
    end else begin
      vel_clamp = vel_full;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hpid_pkg::S_IDLE:   if (start) state_nxt = hpid_pkg::S_CORDIC;
      hpid_pkg::S_CORDIC: if (chain_done) state_nxt = hpid_pkg::S_ERR;
      hpid_pkg::S_ERR:    state_nxt = hpid_pkg::S_INTG;
      hpid_pkg::S_INTG:   state_nxt = hpid_pkg::S_MUL;
      hpid_pkg::S_MUL:    state_nxt = hpid_pkg::S_SUM;
      hpid_pkg::S_SUM:    state_nxt = hpid_pkg::S_DONE;
      hpid_pkg::S_DONE:   if (!out_valid_r || out_tready) state_nxt = hpid_pkg::S_IDLE;
      default:            state_nxt = hpid_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    idle = 1'b0;
    out_load = 1'b0;
    case (state_r)
      hpid_pkg::S_IDLE: idle = 1'b1;
      hpid_pkg::S_DONE: out_load = !out_valid_r || out_tready;
      default: begin
        idle = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  // control state and loop memory
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hpid_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      error_sum_r <= '0;
      last_error_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == hpid_pkg::S_INTG) begin
        error_sum_r <= clear_r ? 32'sd0 : sum_sat;
        last_error_r <= err_r;
      end
    end
  end

  // datapath registers per step
  always_ff @(posedge clk) begin
    if (state_r == hpid_pkg::S_CORDIC && chain_done) begin
      bearing_r <= zero_vec ? 17'sd0 : z_round[27:11];
      clear_r <= 16'(goal_abs) > 16'(cfg.goal_change_threshold);
      reach_r <= reach_abs < 16'sd2048;
    end
    if (state_r == hpid_pkg::S_ERR) begin
      err_r <= wrap_q13(18'(bearing_r) - 18'(robot_heading));
    end
    if (state_r == hpid_pkg::S_INTG) begin
      deriv_r <= 17'(last_error_r) - 17'(err_r);
    end
    if (state_r == hpid_pkg::S_MUL) begin
      prod_p_r <= cfg.gain_p * err_r;
      prod_i_r <= 48'(cfg.gain_i) * 48'(error_sum_r);
      prod_d_r <= 33'(cfg.gain_d) * 33'(deriv_r);
    end
    if (state_r == hpid_pkg::S_SUM) begin
      acc_r <= 50'(prod_p_r) + 50'(prod_i_r) + 50'(prod_d_r);
    end
    if (out_load) begin
      vel_out_r <= vel_clamp[15:0];
      err_out_r <= err_r;
      reach_out_r <= reach_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign turn_velocity = vel_out_r;
  assign heading_error = err_out_r;
  assign goal_reached = reach_out_r;

endmodule

// ===== sv/heading_pid_controller_core.sv =====
// top level of the heading pid controller
`timescale 1ns / 1ps
// Rotational PID controller steering a robot toward a goal pose. One input beat
// carries robot and goal poses; one output beat carries the clamped turn velocity,
// the wrapped heading error and the goal-reached flag. The bearing comes from a
// pre-rotation register and a row of CORDIC vectoring cells, one cell per iteration
// (CORDIC_STEPS, capped at 24), followed by a five-step sequencer for error,
// integrator, products, sum and clamp into the output register. An item passes
// from its input beat through the pre-rotation register, each cell in turn, the
// angle capture and the sequencer steps to the earliest output beat. The next input
// is taken once the previous item has left the sequencer, so a new beat can be
// accepted while the last result still waits at the output register; a result
// stalled there holds the sequencer in its last step and so stalls the input.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata while idle; this is
// for the user to keep to, as the block itself does not enforce it.
module heading_pid_controller_core #(
  parameter int CORDIC_STEPS = hpid_pkg::CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // robot_x, robot_y, robot_heading, target_x, target_y, target_heading
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // turn_velocity, heading_error, goal_reached, zero fill
  output logic [39:0]  out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [15:0]  cfg_wdata
);

  localparam int NCELL = (CORDIC_STEPS > hpid_pkg::ATAN_LEN) ? hpid_pkg::ATAN_LEN : CORDIC_STEPS;

  hpid_pkg::cfg_regs_t cfg_r;
  logic in_accept;

  assign in_accept = in_tvalid && in_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p <= 16'sd5120;
      cfg_r.gain_i <= '0;
      cfg_r.gain_d <= '0;
      cfg_r.vel_limit <= 15'd256;
      cfg_r.goal_change_threshold <= 13'd1;
      cfg_r.prior_goal_heading <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        hpid_pkg::REG_GAIN_P:     cfg_r.gain_p <= cfg_wdata;
        hpid_pkg::REG_GAIN_I:     cfg_r.gain_i <= cfg_wdata;
        hpid_pkg::REG_GAIN_D:     cfg_r.gain_d <= cfg_wdata;
        hpid_pkg::REG_MAX_VEL:    cfg_r.vel_limit <= cfg_wdata[14:0];
        hpid_pkg::REG_GOAL_THR:   cfg_r.goal_change_threshold <= cfg_wdata[12:0];
        hpid_pkg::REG_PRIOR_GOAL: cfg_r.prior_goal_heading <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input field unpack
  logic signed [23:0] rx, ry, tx, ty;
  logic signed [15:0] rh, th;
  logic signed [24:0] dx, dy;

  assign rx = in_tdata[23:0];
  assign ry = in_tdata[47:24];
  assign rh = in_tdata[63:48];
  assign tx = in_tdata[87:64];
  assign ty = in_tdata[111:88];
  assign th = in_tdata[127:112];
  assign dx = 25'(tx) - 25'(rx);
  assign dy = 25'(ty) - 25'(ry);

  // pre-rotation into the right half plane
  hpid_pkg::cordic_beat_t pre_r;
  logic signed [15:0] rh_r, th_r;
  logic zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r.valid <= 1'b0;
    end else begin
      pre_r.valid <= in_accept;
    end
    if (in_accept) begin
      if (dx < 0) begin
        pre_r.x <= -hpid_pkg::XW'(dx);
        pre_r.y <= -hpid_pkg::XW'(dy);
        pre_r.z <= (dy >= 0) ? hpid_pkg::Q24_PI : -hpid_pkg::Q24_PI;
      end else begin
        pre_r.x <= hpid_pkg::XW'(dx);
        pre_r.y <= hpid_pkg::XW'(dy);
        pre_r.z <= '0;
      end
      zero_r <= (dx == 0) && (dy == 0);
      rh_r <= rh;
      th_r <= th;
    end
  end

  // row of cordic cells
  hpid_pkg::cordic_beat_t chain [0:NCELL];

  assign chain[0] = pre_r;

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    hpid_cell #(.STEP(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .beat_in  (chain[g]),
      .beat_out (chain[g+1])
    );
  end

  // pid sequencer and output register
  logic signed [15:0] vel, err;
  logic reached;

  hpid_pid u_pid (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (in_accept),
    .chain_done     (chain[NCELL].valid),
    .chain_z        (chain[NCELL].z),
    .zero_vec       (zero_r),
    .robot_heading  (rh_r),
    .target_heading (th_r),
    .cfg            (cfg_r),
    .out_tready     (out_tready),
    .idle           (in_tready),
    .out_tvalid     (out_tvalid),
    .turn_velocity  (vel),
    .heading_error  (err),
    .goal_reached   (reached)
  );

  assign out_tdata = {7'd0, reached, err, vel};

endmodule

// ===== sv/hpid_checker.sv =====
// port-level checks for the heading pid controller, bound to the top level
`timescale 1ns / 1ps
module hpid_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output beat changed");

  // one item at a time: busy right after an accepted beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while item in flight");

  // no result appears the cycle after an input beat
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result appeared too early");

  // heading error stays wrapped, velocity never hits the most negative code
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[31:16]) <= 16'sd25736)
      && ($signed(out_tdata[31:16]) >= -16'sd25735)
      && (out_tdata[15:0] != 16'h8000))
    else $error("output field out of range");

endmodule

bind heading_pid_controller_core hpid_checker u_hpid_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
